// ----- rtl/core/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the priority thread scheduler
// sizes, event and error codes, and the structs passed along the cell chain
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int NUM_PRIORITIES = 32;
  localparam int TIMEOUT_BITS   = 32;
  localparam int MASK_BITS      = 32;
  localparam int SLOT_W         = 6;
  localparam int TICKS_W        = 32;
  // one present bit for every code of the priority field
  localparam int PRES_W         = 2 ** SLOT_W;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DELAY = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_START = 2'd1,
    ERR_IDLE  = 2'd2,
    ERR_ZERO  = 2'd3
  } err_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_PICK = 1'b1
  } state_t;

  // event broadcast to every cell on the accepting edge
  typedef struct packed {
    logic                    apply;
    logic [1:0]              op;
    logic [SLOT_W-1:0]       prio;
    logic [SLOT_W-1:0]       cur;
    logic                    ok;
    logic [TIMEOUT_BITS-1:0] tval;
  } cmd_t;

  // priority search token passed from higher to lower cells
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } pick_t;

  // per-cell status seen by the top level
  typedef struct packed {
    logic present;
    logic ready;
  } cell_stat_t;

endpackage

// ----- rtl/core/priority_thread_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// priority_thread_scheduler_unit: bitmap priority scheduler with tick delays
// start, delay and tick events over a chain of priority slot cells
// ----------------------------------------------------------------------------
// order: the event beat updates the slots on the accepting edge, then in the
//   pick state the result of the priority search down the cell chain and the
//   result strobe are registered; no new event beat is taken while busy in
//   the pick state
// reset: all slots empty, idle thread current, no result pending
// the receiver cannot stall: each result beat shows for one cycle only
module priority_thread_scheduler_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [pts_pkg::SLOT_W-1:0]  prio,
  input  logic [pts_pkg::TICKS_W-1:0] ticks,
  output logic                        done,
  output logic [pts_pkg::SLOT_W-1:0]  next_thread,
  output logic                        switch_request,
  output logic [1:0]                  error,
  output logic [pts_pkg::MASK_BITS-1:0] ready_mask
);

  pts_pkg::state_t   state;
  pts_pkg::state_t   state_next;
  pts_pkg::err_t     err_now;
  pts_pkg::err_t     err_q;
  pts_pkg::cmd_t     cmd;
  logic              accept;
  logic              idle_present;
  logic [pts_pkg::SLOT_W-1:0] current;
  logic [pts_pkg::PRES_W-1:0] present_all;
  logic [pts_pkg::NUM_PRIORITIES-1:0] ready_vec;
  logic              sat;
  logic [pts_pkg::TIMEOUT_BITS-1:0] tval;
  pts_pkg::pick_t    chain [pts_pkg::NUM_PRIORITIES+1];
  pts_pkg::cell_stat_t stat [pts_pkg::NUM_PRIORITIES];

  assign accept = start && !busy;

  // present bits by priority, idle thread at bit zero, unused codes read zero
  always_comb begin
    present_all    = '0;
    present_all[0] = idle_present;
    for (int i = 0; i < pts_pkg::NUM_PRIORITIES; i++) begin
      present_all[i+1] = stat[i].present;
      ready_vec[i]     = stat[i].ready;
    end
  end

  // long delays saturate to the largest count
  assign sat  = |(ticks >> pts_pkg::TIMEOUT_BITS);
  assign tval = sat ? '1 : ticks[pts_pkg::TIMEOUT_BITS-1:0];

  // event check against the state before the event
  always_comb begin
    err_now = pts_pkg::ERR_NONE;
    case (op)
      pts_pkg::OP_START: begin
        if (prio > pts_pkg::SLOT_W'(pts_pkg::NUM_PRIORITIES) || present_all[prio]) begin
          err_now = pts_pkg::ERR_START;
        end
      end
      pts_pkg::OP_DELAY: begin
        if (current == '0) begin
          err_now = pts_pkg::ERR_IDLE;
        end else if (ticks == '0) begin
          err_now = pts_pkg::ERR_ZERO;
        end
      end
      default: err_now = pts_pkg::ERR_NONE;
    endcase
  end

  // slots update on the accepting edge
  always_comb begin
    cmd.apply = accept;
    cmd.op    = op;
    cmd.prio  = prio;
    cmd.cur   = current;
    cmd.ok    = (err_now == pts_pkg::ERR_NONE);
    cmd.tval  = tval;
  end

  // search token enters at the highest slot
  assign chain[pts_pkg::NUM_PRIORITIES] = '0;

  for (genvar g = 0; g < pts_pkg::NUM_PRIORITIES; g++) begin : g_slot
    pts_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .slot     (pts_pkg::SLOT_W'(g + 1)),
      .cmd      (cmd),
      .pick_in  (chain[g+1]),
      .pick_out (chain[g]),
      .stat     (stat[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    unique case (state)
      pts_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = pts_pkg::ST_PICK;
        end
      end
      pts_pkg::ST_PICK: begin
        busy       = 1'b1;
        state_next = pts_pkg::ST_IDLE;
      end
      default: state_next = pts_pkg::ST_IDLE;
    endcase
  end

  // control: idle slot presence, current thread, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_present <= 1'b0;
      current      <= '0;
      done         <= 1'b0;
    end else begin
      done <= (state == pts_pkg::ST_PICK);
      if (accept && op == pts_pkg::OP_START && err_now == pts_pkg::ERR_NONE &&
          prio == '0) begin
        idle_present <= 1'b1;
      end
      if (state == pts_pkg::ST_PICK) begin
        current <= chain[0].idx;
      end
    end
  end

  // error held from the event beat to the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      err_q <= err_now;
    end
  end

  // result beat registers
  always_ff @(posedge clk) begin
    if (state == pts_pkg::ST_PICK) begin
      next_thread    <= chain[0].idx;
      switch_request <= (chain[0].idx != current);
      error          <= err_q;
      ready_mask     <= pts_pkg::MASK_BITS'(ready_vec);
    end
  end

endmodule

// ----- rtl/core/pts_cell.sv -----
// ----------------------------------------------------------------------------
// pts_cell: one priority slot of the scheduler
// holds present, ready and delayed flags and the tick countdown of its slot,
// and passes the priority search token on to the next lower slot
// ----------------------------------------------------------------------------
module pts_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [pts_pkg::SLOT_W-1:0] slot,
  input  pts_pkg::cmd_t            cmd,
  input  pts_pkg::pick_t           pick_in,
  output pts_pkg::pick_t           pick_out,
  output pts_pkg::cell_stat_t      stat
);

  logic                             present;
  logic                             ready;
  logic                             delayed;
  logic [pts_pkg::TIMEOUT_BITS-1:0] count;
  logic                             hit_start;
  logic                             hit_delay;
  logic                             hit_tick;
  logic                             expire;

  assign hit_start = cmd.apply && cmd.ok && (cmd.op == pts_pkg::OP_START) &&
                     (cmd.prio == slot);
  assign hit_delay = cmd.apply && cmd.ok && (cmd.op == pts_pkg::OP_DELAY) &&
                     (cmd.cur == slot);
  assign hit_tick  = cmd.apply && (cmd.op == pts_pkg::OP_TICK) && delayed;
  // count of one or zero reaches zero on this tick
  assign expire    = count <= pts_pkg::TIMEOUT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
      ready   <= 1'b0;
      delayed <= 1'b0;
    end else begin
      if (hit_start) begin
        present <= 1'b1;
        ready   <= 1'b1;
      end
      if (hit_delay) begin
        ready   <= 1'b0;
        delayed <= 1'b1;
      end
      if (hit_tick && expire) begin
        ready   <= 1'b1;
        delayed <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit_delay) begin
      count <= cmd.tval;
    end else if (hit_tick && count != '0) begin
      count <= count - pts_pkg::TIMEOUT_BITS'(1);
    end
  end

  // first ready slot from the top claims the token
  always_comb begin
    pick_out.found = pick_in.found | ready;
    pick_out.idx   = (ready && !pick_in.found) ? slot : pick_in.idx;
  end

  assign stat.present = present;
  assign stat.ready   = ready;

endmodule
